FILE: hdl/assert_macros.svh
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed: label");

// Implication checked on the same edge.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: label");

// Implication checked on the following edge.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: label");

`endif

FILE: hdl/hvp_pkg.sv
// Types, constants and helper functions of the HTTP version token parser.
package hvp_pkg;

   // Result status codes
   localparam logic [1:0] ST_MORE = 2'd0;
   localparam logic [1:0] ST_OK   = 2'd1;
   localparam logic [1:0] ST_ERR  = 2'd2;

   // Request actions
   localparam logic ACT_CONSUME = 1'b0;
   localparam logic ACT_RESTART = 1'b1;

   // Characters of the token
   localparam logic [7:0] CH_H     = 8'h48;
   localparam logic [7:0] CH_T     = 8'h54;
   localparam logic [7:0] CH_P     = 8'h50;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_9     = 8'h39;

   localparam logic [15:0] ACC_MAX = 16'hFFFF;

   // Position in the token, one-hot
   typedef enum logic [8:0] {
      PH_H     = 9'b000000001,
      PH_T1    = 9'b000000010,
      PH_T2    = 9'b000000100,
      PH_P     = 9'b000001000,
      PH_SLASH = 9'b000010000,
      PH_MAJ0  = 9'b000100000,
      PH_MAJ   = 9'b001000000,
      PH_MIN0  = 9'b010000000,
      PH_MIN   = 9'b100000000
   } phase_type;

   // One request
   typedef struct packed {
      logic       action;
      logic [7:0] char_byte;
   } req_item_type;

   // One response
   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] major_number;
      logic [15:0] minor_number;
   } rsp_item_type;

   // acc * 10 + digit, saturating at 16 bits
   function automatic logic [15:0] acc_digit(input logic [15:0] acc, input logic [3:0] digit);
      logic [19:0] wide;
      wide = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {16'h0000, digit};
      if (wide[19:16] != 4'h0) begin
         return ACC_MAX;
      end
      return wide[15:0];
   endfunction

endpackage

FILE: hdl/hvp_in_stage.sv
// Input register of the parser: holds one request until the parse stage takes it.
module hvp_in_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  hvp_pkg::req_item_type req_item,
   input  logic                 advance,
   output logic                 item_valid,
   output hvp_pkg::req_item_type item
);
   import hvp_pkg::*;

   logic         valid_ff, valid_in;
   req_item_type item_ff, item_in;
   logic         accept;

   // Take a new request when empty or when the held one moves on
   assign req_ready = !valid_ff || advance;
   assign accept    = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (accept) begin
         valid_in = 1'b1;
         item_in  = req_item;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

FILE: hdl/hvp_parse.sv
// Phase machine and digit accumulators; decodes one request per step.
module hvp_parse (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  hvp_pkg::req_item_type item,
   output logic                  emit,
   output hvp_pkg::rsp_item_type result
);
   import hvp_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [15:0] major_ff, major_in;
   logic [15:0] minor_ff, minor_in;
   logic        is_dec;
   logic [3:0]  digit;
   logic [7:0]  b;

   assign b      = item.char_byte;
   assign is_dec = b inside {[CH_0:CH_9]};
   assign digit  = b[3:0];

   // Restart gives no response
   assign emit = step && (item.action == ACT_CONSUME);

   // Next phase, accumulators and response for the held byte
   always_comb begin
      phase_in            = phase_ff;
      major_in            = major_ff;
      minor_in            = minor_ff;
      result.status       = ST_ERR;
      result.major_number = 16'h0000;
      result.minor_number = 16'h0000;
      case (phase_ff)
         PH_H: begin
            if (b == CH_H) begin
               phase_in      = PH_T1;
               result.status = ST_MORE;
            end
         end
         PH_T1: begin
            if (b == CH_T) begin
               phase_in      = PH_T2;
               result.status = ST_MORE;
            end
         end
         PH_T2: begin
            if (b == CH_T) begin
               phase_in      = PH_P;
               result.status = ST_MORE;
            end
         end
         PH_P: begin
            if (b == CH_P) begin
               phase_in      = PH_SLASH;
               result.status = ST_MORE;
            end
         end
         PH_SLASH: begin
            if (b == CH_SLASH) begin
               phase_in      = PH_MAJ0;
               result.status = ST_MORE;
            end
         end
         PH_MAJ0: begin
            if (is_dec) begin
               major_in      = {12'h000, digit};
               phase_in      = PH_MAJ;
               result.status = ST_MORE;
            end
         end
         PH_MAJ: begin
            if (b == CH_DOT) begin
               phase_in      = PH_MIN0;
               result.status = ST_MORE;
            end else if (is_dec) begin
               major_in      = acc_digit(major_ff, digit);
               result.status = ST_MORE;
            end
         end
         PH_MIN0: begin
            if (is_dec) begin
               minor_in      = {12'h000, digit};
               phase_in      = PH_MIN;
               result.status = ST_MORE;
            end
         end
         PH_MIN: begin
            if (is_dec) begin
               minor_in      = acc_digit(minor_ff, digit);
               result.status = ST_MORE;
            end else begin
               result.status       = ST_OK;
               result.major_number = major_ff;
               result.minor_number = minor_ff;
            end
         end
         default: begin
            result.status = ST_ERR;
         end
      endcase
      // Restart only rewinds the phase
      if (item.action == ACT_RESTART) begin
         phase_in = PH_H;
         major_in = major_ff;
         minor_in = minor_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_H;
         major_ff <= 16'h0000;
         minor_ff <= 16'h0000;
      end else if (step) begin
         phase_ff <= phase_in;
         major_ff <= major_in;
         minor_ff <= minor_in;
      end
   end

endmodule

FILE: hdl/hvp_out_stage.sv
// Response register of the parser.
module hvp_out_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  hvp_pkg::rsp_item_type result,
   output logic                  can_load,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output hvp_pkg::rsp_item_type rsp_item
);
   import hvp_pkg::*;

   logic         valid_ff, valid_in;
   rsp_item_type data_ff, data_in;

   // Room for a new response when empty or being drained
   assign can_load = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = result;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_item  = data_ff;

endmodule

FILE: hdl/http_version_token_parser.sv
// Top level of the HTTP version token parser.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  req_action, req_char_byte
//   rsp      out        rsp_valid/rsp_ready  rsp_status, rsp_major_number, rsp_minor_number
//
// One request per cycle sustained while rsp_ready is high; a consumed byte's response
// passes through the input register, then the response register.
// A restart request rewinds the phase and yields no response.
// Reset is synchronous and returns the parser to the expect-'H' phase.
// A stalled response holds in its register; the input register keeps accepting
// until it too is full.
module http_version_token_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_action,
   input  logic [7:0]  req_char_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_major_number,
   output logic [15:0] rsp_minor_number
);
   import hvp_pkg::*;

   req_item_type req_item, item;
   rsp_item_type result, rsp_item;
   logic         item_valid, advance, can_load, emit;

   assign req_item.action    = req_action;
   assign req_item.char_byte = req_char_byte;

   // Held request moves on when the response register has room
   assign advance = item_valid && can_load;

   hvp_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   hvp_parse u_parse (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (item),
      .emit   (emit),
      .result (result)
   );

   hvp_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (emit),
      .result    (result),
      .can_load  (can_load),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   assign rsp_status       = rsp_item.status;
   assign rsp_major_number = rsp_item.major_number;
   assign rsp_minor_number = rsp_item.minor_number;

endmodule

FILE: hdl/hvp_checker.sv
// Port-level checks of the HTTP version token parser, bound to the top level.
`include "assert_macros.svh"

module hvp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [15:0] rsp_major_number,
   input logic [15:0] rsp_minor_number
);
   import hvp_pkg::*;

   // Only the three defined status codes appear
   `ASSERT_IMPL(a_status_code, clock, reset, rsp_valid, rsp_status == ST_MORE || rsp_status == ST_OK || rsp_status == ST_ERR)

   // Version numbers are zero unless the token completed
   `ASSERT_IMPL(a_zero_numbers, clock, reset, rsp_valid && rsp_status != ST_OK, rsp_major_number == 16'h0000 && rsp_minor_number == 16'h0000)

   // Stalled response holds its payload
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_major_number) && $stable(rsp_minor_number))

   // An idle parser with nothing pending is always ready
   `ASSERT_NEXT(a_ready_after_idle, clock, reset, !req_valid && !rsp_valid, req_ready)

endmodule

bind http_version_token_parser hvp_checker u_hvp_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_status       (rsp_status),
   .rsp_major_number (rsp_major_number),
   .rsp_minor_number (rsp_minor_number)
);
